>>> rtl/dll_pkg.sv
// ----------------------------------------------------------------------------
// dll_pkg
// Shared constants and types for the doubly linked list engine.
// ----------------------------------------------------------------------------
`default_nettype none
package dll_pkg;
   localparam int POOL_DEPTH = 32;
   localparam int DATA_WIDTH = 32;
   localparam int LINK_W     = $clog2(POOL_DEPTH + 1);
   localparam int ADDR_W     = $clog2(POOL_DEPTH);
   localparam int RESULT_CAP = 32;
   localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(POOL_DEPTH);

   localparam logic [2:0] CMD_INS_FRONT = 3'd0;
   localparam logic [2:0] CMD_INS_BACK  = 3'd1;
   localparam logic [2:0] CMD_INS_AFTER = 3'd2;
   localparam logic [2:0] CMD_DEL_FRONT = 3'd3;
   localparam logic [2:0] CMD_DEL_BACK  = 3'd4;
   localparam logic [2:0] CMD_DEL_VALUE = 3'd5;
   localparam logic [2:0] CMD_READ_OUT  = 3'd6;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_NOKEY = 2'd2;
   localparam logic [1:0] ST_FULL  = 2'd3;

   // one result beat from the sequencer to the output register
   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] data;
      logic        last;
      logic [5:0]  count;
   } rsp_type;

   function automatic logic [31:0] word_out(input logic [DATA_WIDTH-1:0] w);
      return 32'(signed'(w));
   endfunction
endpackage
`default_nettype wire

>>> rtl/doubly_linked_list_engine_top.sv
// ----------------------------------------------------------------------------
// doubly_linked_list_engine_top
// Ordered list of signed words in a 32-node pool with a free chain.
// ----------------------------------------------------------------------------
// A front/back insert or delete steps through dispatch, read, wait, check,
// link or unlink and emit states; key searches repeat read, wait and check
// per node visited and read-out adds emit per node (one access of the link
// and data RAMs per step, up to 32 nodes), plus stalls on the result side.
// After reset a pass builds the free chain, during which req_stall is high.
// A new command is accepted only after every prior result is transferred.
`default_nettype none
module doubly_linked_list_engine_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_cmd,
   input  wire logic [31:0] req_key,
   input  wire logic [31:0] req_value,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [31:0]      rsp_data,
   output logic             rsp_last,
   output logic [5:0]       rsp_count
);
   logic busy;
   dll_pkg::rsp_type rsp;

   dll_seq u_seq (
      .clock, .reset, .start(req_valid && !busy), .cmd(req_cmd), .key(req_key),
      .value(req_value), .busy, .out_valid(rsp_valid), .out_stall(rsp_stall),
      .out_rsp(rsp));

   // result fields
   assign req_stall  = busy;
   assign rsp_status = rsp.status;
   assign rsp_data   = rsp.data;
   assign rsp_last   = rsp.last;
   assign rsp_count  = rsp.count;
endmodule
`default_nettype wire

>>> rtl/dll_ram.sv
// ----------------------------------------------------------------------------
// dll_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module dll_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

>>> rtl/dll_seq.sv
// ----------------------------------------------------------------------------
// dll_seq
// Command sequencer: walks and relinks the node pool one memory access at a
// time through a single compare unit and one read port per store.
// ----------------------------------------------------------------------------
`default_nettype none
module dll_seq (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [2:0]          cmd,
   input  wire logic [31:0]         key,
   input  wire logic [31:0]         value,
   output logic                     busy,
   output logic                     out_valid,
   input  wire logic                out_stall,
   output dll_pkg::rsp_type         out_rsp
);
   localparam int LW = dll_pkg::LINK_W;
   localparam int AW = dll_pkg::ADDR_W;
   localparam int DW = dll_pkg::DATA_WIDTH;

   typedef enum logic [10:0] {
      S_IDLE   = 11'b00000000001,
      S_DISP   = 11'b00000000010,
      S_RD     = 11'b00000000100,
      S_WAIT   = 11'b00000001000,
      S_CHK    = 11'b00000010000,
      S_LINK1  = 11'b00000100000,
      S_LINK2  = 11'b00001000000,
      S_ULNK1  = 11'b00010000000,
      S_ULNK2  = 11'b00100000000,
      S_EMIT   = 11'b01000000000,
      S_INIT   = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   logic [2:0]    cmd_ff;
   logic [DW-1:0] key_ff, val_ff;
   logic [LW-1:0] head_ff, tail_ff, free_ff, cur_ff, at_ff;
   logic [LW-1:0] head_in, tail_in, free_in, cur_in, at_in;
   logic [5:0]    count_ff, count_in, steps_ff, steps_in;
   logic [AW:0]   init_ff, init_in;
   logic          ov_ff, ov_in;
   dll_pkg::rsp_type rsp_ff, rsp_in;
   logic [DW-1:0] wd_ff, wd_in;

   // memory ports
   logic          d_we, n_we, p_we;
   logic [AW-1:0] d_wa, n_wa, p_wa, rd_a;
   logic [DW-1:0] d_wd, d_rd;
   logic [LW-1:0] n_wd, p_wd, n_rd, p_rd;

   dll_ram #(.WIDTH(DW), .DEPTH(dll_pkg::POOL_DEPTH)) u_data (
      .clock, .wr_en(d_we), .wr_addr(d_wa), .wr_data(d_wd),
      .rd_addr(rd_a), .rd_data(d_rd));
   dll_ram #(.WIDTH(LW), .DEPTH(dll_pkg::POOL_DEPTH)) u_next (
      .clock, .wr_en(n_we), .wr_addr(n_wa), .wr_data(n_wd),
      .rd_addr(rd_a), .rd_data(n_rd));
   dll_ram #(.WIDTH(LW), .DEPTH(dll_pkg::POOL_DEPTH)) u_prev (
      .clock, .wr_en(p_we), .wr_addr(p_wa), .wr_data(p_wd),
      .rd_addr(rd_a), .rd_data(p_rd));

   function automatic logic vld(input logic [LW-1:0] i);
      return i < dll_pkg::NIL_LINK;
   endfunction

   assign busy      = (state_ff != S_IDLE) || ov_ff;
   assign out_valid = ov_ff;
   assign out_rsp   = rsp_ff;

   // sequencer
   always_comb begin
      logic hit;
      state_in = state_ff; head_in = head_ff; tail_in = tail_ff; free_in = free_ff;
      cur_in = cur_ff; at_in = at_ff; count_in = count_ff; steps_in = steps_ff;
      init_in = init_ff; ov_in = ov_ff; rsp_in = rsp_ff; wd_in = wd_ff;
      d_we = 1'b0; n_we = 1'b0; p_we = 1'b0;
      d_wa = '0; n_wa = '0; p_wa = '0; d_wd = val_ff; n_wd = '0; p_wd = '0;
      rd_a = cur_ff[AW-1:0];
      hit = (d_rd == key_ff);
      if (ov_ff && !out_stall) ov_in = 1'b0;
      unique case (state_ff)
         // free chain build after reset
         S_INIT: begin
            n_we = 1'b1; n_wa = init_ff[AW-1:0];
            n_wd = LW'(init_ff) + LW'(1);
            init_in = init_ff + 1'b1;
            if (init_ff == (AW+1)'(dll_pkg::POOL_DEPTH - 1)) state_in = S_IDLE;
         end
         S_IDLE: if (start) state_in = S_DISP;
         S_DISP: begin
            steps_in = '0;
            rsp_in.count = count_ff; rsp_in.last = 1'b1; rsp_in.data = '0;
            priority if (cmd_ff == dll_pkg::CMD_INS_FRONT
                         || cmd_ff == dll_pkg::CMD_INS_BACK) begin
               if (!vld(free_ff)) begin
                  rsp_in.status = dll_pkg::ST_FULL; state_in = S_EMIT;
               end else begin
                  cur_in = free_ff; at_in = free_ff; state_in = S_RD;
               end
            end else if (cmd_ff > dll_pkg::CMD_READ_OUT) begin
               state_in = S_IDLE;
            end else if (!vld(head_ff)) begin
               rsp_in.status = dll_pkg::ST_EMPTY; state_in = S_EMIT;
            end else if (cmd_ff == dll_pkg::CMD_DEL_BACK) begin
               cur_in = tail_ff; state_in = S_RD;
            end else begin
               cur_in = head_ff; state_in = S_RD;
            end
         end
         S_RD: state_in = S_WAIT;     // address presented, data next cycle
         S_WAIT: state_in = S_CHK;
         S_CHK: begin
            wd_in = d_rd;
            priority if (cmd_ff == dll_pkg::CMD_INS_FRONT
                         || cmd_ff == dll_pkg::CMD_INS_BACK) begin
               // cur is the free node; n_rd is its free successor
               free_in = n_rd;
               d_we = 1'b1; d_wa = cur_ff[AW-1:0];
               n_we = 1'b1; n_wa = cur_ff[AW-1:0];
               p_we = 1'b1; p_wa = cur_ff[AW-1:0];
               n_wd = dll_pkg::NIL_LINK; p_wd = dll_pkg::NIL_LINK;
               count_in = count_ff + 6'd1;
               if (!vld(head_ff)) begin
                  head_in = cur_ff; tail_in = cur_ff; state_in = S_EMIT;
               end else if (cmd_ff == dll_pkg::CMD_INS_FRONT) begin
                  n_wd = head_ff; head_in = cur_ff; at_in = head_ff;
                  state_in = S_LINK1;
               end else begin
                  p_wd = tail_ff; tail_in = cur_ff; at_in = tail_ff;
                  state_in = S_LINK1;
               end
               rsp_in.status = dll_pkg::ST_OK;
               rsp_in.data   = dll_pkg::word_out(val_ff);
               rsp_in.count  = count_ff + 6'd1;
            end else if (cmd_ff == dll_pkg::CMD_READ_OUT) begin
               // hold the listed word until the output register is free
               if (!ov_ff || !out_stall) begin
                  rsp_in.status = dll_pkg::ST_OK;
                  rsp_in.data   = dll_pkg::word_out(d_rd);
                  rsp_in.last   = !vld(n_rd) || steps_ff == 6'(dll_pkg::RESULT_CAP - 1);
                  steps_in = steps_ff + 6'd1; cur_in = n_rd;
                  state_in = S_EMIT;
               end
            end else if ((cmd_ff == dll_pkg::CMD_INS_AFTER
                          || cmd_ff == dll_pkg::CMD_DEL_VALUE) && !hit) begin
               steps_in = steps_ff + 6'd1; cur_in = n_rd;
               if (!vld(n_rd) || steps_ff == 6'(dll_pkg::POOL_DEPTH - 1)) begin
                  rsp_in.status = dll_pkg::ST_NOKEY; state_in = S_EMIT;
               end else state_in = S_RD;
            end else if (cmd_ff == dll_pkg::CMD_INS_AFTER) begin
               // key node found: cur=at, n_rd its successor
               if (!vld(free_ff)) begin
                  rsp_in.status = dll_pkg::ST_FULL; state_in = S_EMIT;
               end else begin
                  at_in = cur_ff; cur_in = free_ff; steps_in = '0;
                  n_we = 1'b1; n_wa = cur_ff[AW-1:0]; n_wd = free_ff;
                  d_we = 1'b1; d_wa = free_ff[AW-1:0];
                  p_we = 1'b1; p_wa = free_ff[AW-1:0]; p_wd = cur_ff;
                  wd_in = DW'(n_rd);   // remember old successor
                  count_in = count_ff + 6'd1;
                  rsp_in.status = dll_pkg::ST_OK;
                  rsp_in.data   = dll_pkg::word_out(val_ff);
                  rsp_in.count  = count_ff + 6'd1;
                  state_in = S_LINK2;
               end
            end else begin
               // delete node cur: p_rd / n_rd are neighbors
               at_in = p_rd; wd_in = d_rd;
               if (vld(p_rd)) begin
                  n_we = 1'b1; n_wa = p_rd[AW-1:0]; n_wd = n_rd;
               end else head_in = n_rd;
               if (vld(n_rd)) begin
                  p_we = 1'b1; p_wa = n_rd[AW-1:0]; p_wd = p_rd;
               end else tail_in = p_rd;
               state_in = S_ULNK1;
            end
         end
         // back-link of the old head or forward link of the old tail
         S_LINK1: begin
            if (cmd_ff == dll_pkg::CMD_INS_FRONT) begin
               p_we = 1'b1; p_wa = at_ff[AW-1:0]; p_wd = head_ff;
            end else begin
               n_we = 1'b1; n_wa = at_ff[AW-1:0]; n_wd = tail_ff;
            end
            state_in = S_EMIT;
         end
         // new node after at: free head advance needs its old next link
         S_LINK2: begin
            rd_a = cur_ff[AW-1:0];
            state_in = S_ULNK2;
         end
         S_ULNK2: begin
            // n_rd is free successor of new node (read issued last cycle)
            free_in = n_rd;
            n_we = 1'b1; n_wa = cur_ff[AW-1:0]; n_wd = wd_ff[LW-1:0];
            if (vld(wd_ff[LW-1:0])) begin
               p_we = 1'b1; p_wa = wd_ff[AW-1:0]; p_wd = cur_ff;
            end else tail_in = cur_ff;
            state_in = S_EMIT;
         end
         // return node to the free chain
         S_ULNK1: begin
            n_we = 1'b1; n_wa = cur_ff[AW-1:0]; n_wd = free_ff;
            free_in = cur_ff;
            if (count_ff != 6'd0) count_in = count_ff - 6'd1;
            rsp_in.status = dll_pkg::ST_OK;
            rsp_in.data   = dll_pkg::word_out(wd_ff);
            rsp_in.count  = (count_ff != 6'd0) ? count_ff - 6'd1 : count_ff;
            state_in = S_EMIT;
         end
         S_EMIT: if (!ov_ff || !out_stall) begin
            ov_in = 1'b1;
            if (cmd_ff == dll_pkg::CMD_READ_OUT && !rsp_in.last && rsp_ff.status
                == dll_pkg::ST_OK && !rsp_ff.last) state_in = S_RD;
            else state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT; init_ff <= '0; ov_ff <= 1'b0;
         head_ff <= dll_pkg::NIL_LINK; tail_ff <= dll_pkg::NIL_LINK;
         free_ff <= '0; count_ff <= '0;
      end else begin
         state_ff <= state_in; init_ff <= init_in; ov_ff <= ov_in;
         head_ff <= head_in; tail_ff <= tail_in; free_ff <= free_in;
         count_ff <= count_in;
      end
      cur_ff <= cur_in; at_ff <= at_in; steps_ff <= steps_in;
      rsp_ff <= rsp_in; wd_ff <= wd_in;
      if (start && state_ff == S_IDLE) begin
         cmd_ff <= cmd; key_ff <= DW'(key); val_ff <= DW'(value);
      end
   end
endmodule
`default_nettype wire

>>> rtl/dll_checker.sv
// ----------------------------------------------------------------------------
// dll_checker
// Port-level checks on the doubly linked list engine.
// ----------------------------------------------------------------------------
`default_nettype none
module dll_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [1:0] rsp_status,
   input wire logic [31:0] rsp_data,
   input wire logic       rsp_last,
   input wire logic [5:0] rsp_count
);
   // no command taken while a result waits
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("command accepted with result pending");
   // error results carry zero data and end the command
   a_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != dll_pkg::ST_OK |-> rsp_data == 32'd0 && rsp_last)
      else $error("bad error result");
   // count never exceeds the pool
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_count <= 6'(dll_pkg::POOL_DEPTH)) else $error("count range");
   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed under stall");
endmodule

bind doubly_linked_list_engine_top dll_checker u_dll_checker (.*);
`default_nettype wire

>>> test/tb_doubly_linked_list_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_doubly_linked_list_engine_top
// Checks the list engine against a behavioral list model kept in the bench.
// Directed cases cover empty list, missing key, full pool and read-out, then
// random command mixes run under three sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module tb_doubly_linked_list_engine_top;
   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] data;
      logic        last;
      logic [5:0]  count;
   } result_type;

   localparam logic [2:0] CMD_UNDEF = 3'd7;
   localparam int WATCHDOG_LIMIT = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_cmd = '0;
   logic [31:0] req_key = '0;
   logic [31:0] req_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_data;
   logic        rsp_last;
   logic [5:0]  rsp_count;

   doubly_linked_list_engine_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_cmd(req_cmd), .req_key(req_key), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_data(rsp_data),
      .rsp_last(rsp_last), .rsp_count(rsp_count)
   );

   always #2 clock = ~clock;

   // list model: ordered contents from head to tail
   logic [31:0] list_words[$];
   result_type  expected_results[$];
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          error_count = 0;
   int          cmds_sent = 0;
   int          results_seen = 0;
   int          idle_cycles = 0;

   function automatic result_type make_result(logic [1:0] st, logic [31:0] d, logic l);
      result_type r;
      r.status = st;
      r.data   = (st == dll_pkg::ST_OK) ? d : 32'd0;
      r.last   = l;
      r.count  = 6'(list_words.size());
      return r;
   endfunction

   function automatic int find_word(logic [31:0] k);
      foreach (list_words[i])
         if (list_words[i] == k) return i;
      return -1;
   endfunction

   // predict the results of one command and update the list model
   function automatic void predict_list_cmd(logic [2:0] cmd, logic [31:0] key,
                                             logic [31:0] value);
      int pos;
      logic [31:0] w;
      case (cmd)
         dll_pkg::CMD_INS_FRONT, dll_pkg::CMD_INS_BACK: begin
            if (list_words.size() >= dll_pkg::POOL_DEPTH) begin
               expected_results.push_back(make_result(dll_pkg::ST_FULL, 0, 1'b1));
            end else begin
               if (cmd == dll_pkg::CMD_INS_FRONT) list_words.push_front(value);
               else list_words.push_back(value);
               expected_results.push_back(make_result(dll_pkg::ST_OK, value, 1'b1));
            end
         end
         dll_pkg::CMD_INS_AFTER: begin
            pos = find_word(key);
            if (list_words.size() == 0)
               expected_results.push_back(make_result(dll_pkg::ST_EMPTY, 0, 1'b1));
            else if (pos < 0)
               expected_results.push_back(make_result(dll_pkg::ST_NOKEY, 0, 1'b1));
            else if (list_words.size() >= dll_pkg::POOL_DEPTH)
               expected_results.push_back(make_result(dll_pkg::ST_FULL, 0, 1'b1));
            else begin
               list_words.insert(pos + 1, value);
               expected_results.push_back(make_result(dll_pkg::ST_OK, value, 1'b1));
            end
         end
         dll_pkg::CMD_DEL_FRONT, dll_pkg::CMD_DEL_BACK, dll_pkg::CMD_DEL_VALUE: begin
            if (list_words.size() == 0) begin
               expected_results.push_back(make_result(dll_pkg::ST_EMPTY, 0, 1'b1));
            end else begin
               if (cmd == dll_pkg::CMD_DEL_FRONT) pos = 0;
               else if (cmd == dll_pkg::CMD_DEL_BACK) pos = list_words.size() - 1;
               else pos = find_word(key);
               if (pos < 0) begin
                  expected_results.push_back(make_result(dll_pkg::ST_NOKEY, 0, 1'b1));
               end else begin
                  w = list_words[pos];
                  list_words.delete(pos);
                  expected_results.push_back(make_result(dll_pkg::ST_OK, w, 1'b1));
               end
            end
         end
         dll_pkg::CMD_READ_OUT: begin
            if (list_words.size() == 0)
               expected_results.push_back(make_result(dll_pkg::ST_EMPTY, 0, 1'b1));
            else
               foreach (list_words[i])
                  if (i < dll_pkg::RESULT_CAP)
                     expected_results.push_back(make_result(dll_pkg::ST_OK,
                        list_words[i], i == list_words.size() - 1
                        || i == dll_pkg::RESULT_CAP - 1));
         end
         default: ;
      endcase
   endfunction

   // send one command, with random idle cycles ahead of it
   task automatic send_cmd(logic [2:0] cmd, logic [31:0] key, logic [31:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd   <= cmd;
      req_key   <= key;
      req_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_list_cmd(cmd, key, value);
      cmds_sent++;
      req_valid <= 1'b0;
      // the block is busy right after a transfer, so this edge costs nothing
      @(posedge clock);
   endtask

   task automatic wait_results_drained();
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   // pick a word, usually one in the list so searches hit
   function automatic logic [31:0] pick_key();
      if (list_words.size() != 0 && $urandom_range(99) < 70)
         return list_words[$urandom_range(list_words.size() - 1)];
      return ($urandom_range(3) == 0) ? 32'($urandom_range(7)) : $urandom;
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3: return 32'($urandom_range(7));
         default: return $urandom;
      endcase
   endfunction

   // receiver stall and result checking
   always @(posedge clock) begin
      result_type got, want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_status, rsp_data, rsp_last, rsp_count};
            results_seen++;
            if (expected_results.size() == 0) begin
               $error("unexpected result status=%0d data=%h", rsp_status, rsp_data);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (got.status !== want.status) begin
                  $error("status: expected %0d actual %0d", want.status, got.status);
                  error_count++;
               end
               if (got.data !== want.data) begin
                  $error("data: expected %h actual %h", want.data, got.data);
                  error_count++;
               end
               if (got.last !== want.last) begin
                  $error("last: expected %0d actual %0d", want.last, got.last);
                  error_count++;
               end
               if (got.count !== want.count) begin
                  $error("count: expected %0d actual %0d", want.count, got.count);
                  error_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // watchdog on cycles with no transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d idle cycles", idle_cycles);
         $display("FAIL");
         $finish;
      end
   end

   // empty-list behavior for every command but the two inserts, plus the ignored code
   task automatic test_empty_list();
      for (int c = 0; c < 8; c++)
         if (c != dll_pkg::CMD_INS_FRONT && c != dll_pkg::CMD_INS_BACK)
            send_cmd(3'(c), 32'd0, 32'd0);
   endtask

   // extremes, inserts everywhere, missing keys
   task automatic test_directed_ops();
      send_cmd(dll_pkg::CMD_INS_FRONT, 0, 32'h8000_0000);
      send_cmd(dll_pkg::CMD_INS_BACK, 0, 32'h7fff_ffff);
      send_cmd(dll_pkg::CMD_INS_AFTER, 32'h8000_0000, 32'hffff_ffff);
      send_cmd(dll_pkg::CMD_INS_AFTER, 32'h7fff_ffff, 32'd0);
      send_cmd(dll_pkg::CMD_INS_AFTER, 32'h1234_5678, 32'd5);
      send_cmd(dll_pkg::CMD_DEL_VALUE, 32'h1234_5678, 0);
      send_cmd(dll_pkg::CMD_READ_OUT, 0, 0);
      send_cmd(dll_pkg::CMD_DEL_VALUE, 32'hffff_ffff, 0);
      send_cmd(dll_pkg::CMD_DEL_FRONT, 0, 0);
      send_cmd(dll_pkg::CMD_DEL_BACK, 0, 0);
      send_cmd(CMD_UNDEF, 32'hffff_ffff, 32'hffff_ffff);
      send_cmd(dll_pkg::CMD_READ_OUT, 0, 0);
   endtask

   // fill the pool, hit full on front and after inserts, miss a key, read all 32, then drain
   task automatic test_full_pool();
      while (list_words.size() < dll_pkg::POOL_DEPTH)
         send_cmd(dll_pkg::CMD_INS_BACK, 0, $urandom);
      send_cmd(dll_pkg::CMD_INS_FRONT, 0, 32'd1);
      send_cmd(dll_pkg::CMD_INS_AFTER, list_words[3], 32'd2);
      send_cmd(dll_pkg::CMD_INS_AFTER, ~list_words[0], 32'd2);
      send_cmd(dll_pkg::CMD_READ_OUT, 0, 0);
      while (list_words.size() != 0)
         send_cmd($urandom_range(1) ? dll_pkg::CMD_DEL_FRONT : dll_pkg::CMD_DEL_BACK,
                  0, 0);
   endtask

   // random command mix that keeps the list at mid length
   task automatic test_random_mix(int n);
      logic [2:0] cmd;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 3) cmd = CMD_UNDEF;
         else if ($urandom_range(99) < 8) cmd = dll_pkg::CMD_READ_OUT;
         else if (list_words.size() < 20 && $urandom_range(99) < 60)
            cmd = 3'($urandom_range(2));
         else cmd = 3'($urandom_range(5));
         send_cmd(cmd, pick_key(), pick_value());
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 38;
      recv_idle_pct = 47;
      test_empty_list();
      test_directed_ops();
      test_full_pool();
      test_random_mix(95);
      // hold off until everything has drained
      wait_results_drained();
      send_idle_pct = 47;
      recv_idle_pct = 38;
      test_random_mix(95);
      test_full_pool();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_mix(95);
      wait_results_drained();
      repeat (200) @(posedge clock);
      $display("ran %0d commands, checked %0d results,", cmds_sent, results_seen);
      $display("including empty, missing key, full pool and capped read-out");
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

>>> sim.f
rtl/dll_pkg.sv
rtl/dll_ram.sv
rtl/dll_seq.sv
rtl/doubly_linked_list_engine_top.sv
rtl/dll_checker.sv
test/tb_doubly_linked_list_engine_top.sv
